@@ sv/mcr_pkg.sv @@
// Shared constants and types for the midpoint circle rasterizer.
package mcr_pkg;

	// Default coordinate width
	localparam int COORD_BITS_DEF = 12;

	// Operation codes carried on the input tuser bit
	localparam logic OP_START = 1'b0;
	localparam logic OP_STEP  = 1'b1;

	// Decision term constants
	localparam int DEC_INIT   = 3;
	localparam int DEC_INC_E  = 6;
	localparam int DEC_INC_SE = 10;

	// Pixels emitted per octant step
	localparam int PIX_PER_STEP = 8;
	localparam int PIX_IDX_BITS = $clog2(PIX_PER_STEP);

	// Load request from the step core to the pixel emitter
	typedef struct packed {
		logic load;
		logic done;
	} emit_req_t;

endpackage

@@ sv/mcr_core.sv @@
// Input register, circle state and one decision-term step per octant point.
module mcr_core #(
	parameter int COORD_BITS = mcr_pkg::COORD_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	// request side
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic                    in_op,
	input  logic [COORD_BITS-1:0]   in_cx,
	input  logic [COORD_BITS-1:0]   in_cy,
	input  logic [COORD_BITS-1:0]   in_r,
	// emitter side
	input  logic                    emit_ready,
	output mcr_pkg::emit_req_t      emit_req,
	output logic [COORD_BITS-1:0]   cx,
	output logic [COORD_BITS-1:0]   cy,
	output logic [COORD_BITS-1:0]   ox,
	output logic [COORD_BITS-1:0]   oy
);

	localparam int DW = COORD_BITS + 4;
	localparam int WW = COORD_BITS + 2;

	// input stage
	logic                  valid_s1;
	logic                  op_s1;
	logic [COORD_BITS-1:0] cx_s1, cy_s1, r_s1;

	// circle state
	logic                  active_q;
	logic [COORD_BITS-1:0] cx_q, cy_q, x_q, y_q;
	logic signed [DW-1:0]  d_q;

	logic                  is_start, is_step, consume;
	logic signed [DW-1:0]  x_d, y_d, nd_e, nd_se, nd, d_init;
	logic signed [WW-1:0]  y_w, nx_w, ny;
	logic                  d_neg, done;
	logic [COORD_BITS-1:0] x_next, y_next;

	// handshake: a start or an idle step is absorbed at once,
	// an active step waits for the emitter
	assign is_start = valid_s1 && (op_s1 == mcr_pkg::OP_START);
	assign is_step  = valid_s1 && (op_s1 == mcr_pkg::OP_STEP) && active_q;
	assign consume  = valid_s1 && (!is_step || emit_ready);
	assign in_ready = !valid_s1 || consume;

	// next octant point and decision term
	always_comb begin
		x_d    = {4'b0000, x_q};
		y_d    = {4'b0000, y_q};
		d_neg  = d_q[DW-1];
		nd_e   = d_q + (x_d <<< 2) + DW'(mcr_pkg::DEC_INC_E);
		nd_se  = d_q + ((x_d - y_d) <<< 2) + DW'(mcr_pkg::DEC_INC_SE);
		nd     = d_neg ? nd_e : nd_se;
		y_w    = {2'b00, y_q};
		nx_w   = {2'b00, x_q} + WW'(1);
		ny     = d_neg ? y_w : (y_w - WW'(1));
		done   = nx_w > ny;
		x_next = x_q + COORD_BITS'(1);
		y_next = ny[WW-1] ? '0 : ny[COORD_BITS-1:0];
		d_init = DW'(mcr_pkg::DEC_INIT) - {3'b000, r_s1, 1'b0};
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			op_s1 <= in_op;
			cx_s1 <= in_cx;
			cy_s1 <= in_cy;
			r_s1  <= in_r;
		end
	end

	// circle state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			cx_q     <= '0;
			cy_q     <= '0;
			x_q      <= '0;
			y_q      <= '0;
			d_q      <= '0;
		end else if (consume) begin
			if (is_start) begin
				active_q <= 1'b1;
				cx_q     <= cx_s1;
				cy_q     <= cy_s1;
				x_q      <= '0;
				y_q      <= r_s1;
				d_q      <= d_init;
			end else if (is_step) begin
				active_q <= !done;
				x_q      <= x_next;
				y_q      <= y_next;
				d_q      <= nd;
			end
		end
	end

	// current point goes to the emitter together with the load
	assign emit_req.load = is_step && emit_ready;
	assign emit_req.done = done;
	assign cx = cx_q;
	assign cy = cy_q;
	assign ox = x_q;
	assign oy = y_q;

endmodule

@@ sv/mcr_emit.sv @@
// Eight-way mirror of one octant point, one pixel per cycle while out_ready is high.
module mcr_emit #(
	parameter int COORD_BITS = mcr_pkg::COORD_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  mcr_pkg::emit_req_t        emit_req,
	output logic                      emit_ready,
	input  logic [COORD_BITS-1:0]     cx,
	input  logic [COORD_BITS-1:0]     cy,
	input  logic [COORD_BITS-1:0]     ox,
	input  logic [COORD_BITS-1:0]     oy,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [COORD_BITS+1:0]     pixel_x,
	output logic [COORD_BITS+1:0]     pixel_y,
	output logic                      last_of_step,
	output logic                      circle_done
);

	localparam int PW = COORD_BITS + 2;
	localparam int NP = mcr_pkg::PIX_PER_STEP;
	localparam int IB = mcr_pkg::PIX_IDX_BITS;

	logic                 busy_q, done_q;
	logic [IB-1:0]        cnt_q;
	logic [PW-1:0]        px_q [NP];
	logic [PW-1:0]        py_q [NP];

	logic signed [PW-1:0] cxw, cyw, xw, yw;
	logic                 is_last, take;

	assign is_last    = (cnt_q == IB'(NP - 1));
	assign take       = busy_q && out_ready;
	assign emit_ready = !busy_q || (take && is_last);

	// mirrored coordinates
	always_comb begin
		cxw = {2'b00, cx};
		cyw = {2'b00, cy};
		xw  = {2'b00, ox};
		yw  = {2'b00, oy};
	end

	// pixel registers loaded for a whole step
	always_ff @(posedge clk) begin
		if (emit_req.load) begin
			px_q[0] <= cxw + xw;  py_q[0] <= cyw + yw;
			px_q[1] <= cxw + xw;  py_q[1] <= cyw - yw;
			px_q[2] <= cxw - xw;  py_q[2] <= cyw + yw;
			px_q[3] <= cxw - xw;  py_q[3] <= cyw - yw;
			px_q[4] <= cxw + yw;  py_q[4] <= cyw + xw;
			px_q[5] <= cxw + yw;  py_q[5] <= cyw - xw;
			px_q[6] <= cxw - yw;  py_q[6] <= cyw + xw;
			px_q[7] <= cxw - yw;  py_q[7] <= cyw - xw;
			done_q  <= emit_req.done;
		end
	end

	// pixel sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (emit_req.load) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (take) begin
			if (is_last) begin
				busy_q <= 1'b0;
			end
			cnt_q <= cnt_q + IB'(1);
		end
	end

	assign out_valid    = busy_q;
	assign pixel_x      = px_q[cnt_q];
	assign pixel_y      = py_q[cnt_q];
	assign last_of_step = is_last;
	assign circle_done  = is_last && done_q;

endmodule

@@ sv/midpoint_circle_rasterizer.sv @@
// Top level of the midpoint circle rasterizer.
// Usage:
//  Slave channel: s_axis_tuser is the op (0 = start a circle, 1 = one octant
//  step); s_axis_tdata holds center_x, center_y and radius. A start latches
//  the circle and emits nothing; a step with no active circle is dropped.
//  Master channel: one pixel per transfer, eight per step; tlast marks the
//  eighth pixel of a step and tuser marks the final pixel of the circle.
//  A step reaches tvalid through the input register, then the pixel registers.
//  Throughput: one pixel per cycle while m_axis_tready is high, eight per
//  step, set by the single output port of the pixel sequencer; a waiting
//  step is loaded in the cycle its predecessor's last pixel is taken, so
//  pixels flow without gaps. Starts and idle steps are taken one per cycle
//  unless an active step waits ahead of them.
//  Stalls: when m_axis_tready is low the current pixel holds; the input
//  register still takes requests, but once it holds an active step,
//  s_axis_tready drops until that step can move into the pixel registers.
//  Reset: arst_n clears the active flag and all valid flags; no circle is
//  active afterwards and no pixel is pending.
module midpoint_circle_rasterizer #(
	parameter int COORD_BITS = mcr_pkg::COORD_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_axis_tvalid,
	output logic                                   s_axis_tready,
	// bits up: center_x, center_y, radius, zero fill
	input  logic [((3*COORD_BITS+7)/8)*8-1:0]      s_axis_tdata,
	// op
	input  logic                                   s_axis_tuser,
	output logic                                   m_axis_tvalid,
	input  logic                                   m_axis_tready,
	// bits up: pixel_x, pixel_y, zero fill
	output logic [((2*(COORD_BITS+2)+7)/8)*8-1:0]  m_axis_tdata,
	// last_of_step
	output logic                                   m_axis_tlast,
	// circle_done
	output logic                                   m_axis_tuser
);

	localparam int ODW = ((2*(COORD_BITS+2)+7)/8)*8;
	localparam int PW  = COORD_BITS + 2;

	mcr_pkg::emit_req_t    emit_req;
	logic                  emit_ready;
	logic [COORD_BITS-1:0] cx, cy, ox, oy;
	logic [PW-1:0]         pixel_x, pixel_y;

	// circle state and step arithmetic
	mcr_core #(.COORD_BITS(COORD_BITS)) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_op      (s_axis_tuser),
		.in_cx      (s_axis_tdata[COORD_BITS-1:0]),
		.in_cy      (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
		.in_r       (s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS]),
		.emit_ready (emit_ready),
		.emit_req   (emit_req),
		.cx         (cx),
		.cy         (cy),
		.ox         (ox),
		.oy         (oy)
	);

	// eight-way pixel sequencer
	mcr_emit #(.COORD_BITS(COORD_BITS)) u_emit (
		.clk          (clk),
		.arst_n       (arst_n),
		.emit_req     (emit_req),
		.emit_ready   (emit_ready),
		.cx           (cx),
		.cy           (cy),
		.ox           (ox),
		.oy           (oy),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.pixel_x      (pixel_x),
		.pixel_y      (pixel_y),
		.last_of_step (m_axis_tlast),
		.circle_done  (m_axis_tuser)
	);

	// pack output data
	assign m_axis_tdata = ODW'({pixel_y, pixel_x});

endmodule

@@ sv/mcr_chk.sv @@
// Port-level checks for the midpoint circle rasterizer, bound to the top level.
module mcr_chk #(
	parameter int COORD_BITS = mcr_pkg::COORD_BITS_DEF
) (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  m_axis_tvalid,
	input logic                                  m_axis_tready,
	input logic [((2*(COORD_BITS+2)+7)/8)*8-1:0] m_axis_tdata,
	input logic                                  m_axis_tlast,
	input logic                                  m_axis_tuser
);

	// circle end only on the last pixel of a step
	a_done_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
		else $error("circle_done without last_of_step");

	// the eight pixels of a step come without gaps
	a_step_burst: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
		else $error("gap inside a step burst");

	// nothing pending right after reset
	a_reset_empty: assert property (@(posedge clk)
		!arst_n |=> !m_axis_tvalid)
		else $error("output valid right after reset");

	// stalled pixel holds
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
			&& $stable(m_axis_tuser))
		else $error("stalled pixel changed");

endmodule

bind midpoint_circle_rasterizer mcr_chk #(.COORD_BITS(COORD_BITS)) u_mcr_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast),
	.m_axis_tuser  (m_axis_tuser)
);

@@ test/tb.sv @@
// Testbench for the midpoint circle rasterizer: stream stimulus and a pixel scoreboard.
`timescale 1ns / 1ps

module tb;

	localparam int CB     = mcr_pkg::COORD_BITS_DEF;
	localparam int PB     = CB + 2;
	localparam int DB     = CB + 4;
	localparam int S_W    = ((3*CB+7)/8)*8;
	localparam int M_W    = ((2*PB+7)/8)*8;
	localparam int C_MAX  = (1 << CB) - 1;

	// One expected pixel on the master side
	typedef struct {
		logic signed [PB-1:0] px;
		logic signed [PB-1:0] py;
		logic                 last;
		logic                 done;
	} pixel_t;

	// Circle state tracker and queue of pixels still owed by the block
	class circle_scoreboard;
		pixel_t              expected_pixels[$];
		bit                  circle_active;
		bit [CB-1:0]         org_x, org_y, col_off, row_off;
		logic signed [DB-1:0] err_term;
		int                  n_requests, n_starts, n_pixels, n_circles, n_errors;

		function void queue_pixel(int px, int py, bit last, bit done);
			pixel_t p;
			p.px = PB'(px);
			p.py = PB'(py);
			p.last = last;
			p.done = done;
			expected_pixels.push_back(p);
		endfunction

		// Update the circle state for one accepted request and queue its pixels
		function void take_request(logic op, logic [CB-1:0] cx, logic [CB-1:0] cy,
				logic [CB-1:0] r);
			int x, y, nx, ny, nd, ox, oy;
			bit done;
			n_requests++;
			if (op == mcr_pkg::OP_START) begin
				n_starts++;
				org_x = cx;
				org_y = cy;
				col_off = '0;
				row_off = r;
				err_term = DB'(mcr_pkg::DEC_INIT - 2 * int'(r));
				circle_active = 1'b1;
				return;
			end
			// step with no circle running is dropped
			if (!circle_active)
				return;
			x = col_off;
			y = row_off;
			nd = err_term;
			if (err_term < 0) begin
				nd = nd + 4 * x + mcr_pkg::DEC_INC_E;
				ny = y;
			end else begin
				nd = nd + 4 * (x - y) + mcr_pkg::DEC_INC_SE;
				ny = y - 1;
			end
			nx = x + 1;
			done = nx > ny;
			ox = org_x;
			oy = org_y;
			queue_pixel(ox + x, oy + y, 1'b0, 1'b0);
			queue_pixel(ox + x, oy - y, 1'b0, 1'b0);
			queue_pixel(ox - x, oy + y, 1'b0, 1'b0);
			queue_pixel(ox - x, oy - y, 1'b0, 1'b0);
			queue_pixel(ox + y, oy + x, 1'b0, 1'b0);
			queue_pixel(ox + y, oy - x, 1'b0, 1'b0);
			queue_pixel(ox - y, oy + x, 1'b0, 1'b0);
			queue_pixel(ox - y, oy - x, 1'b1, done);
			err_term = DB'(nd);
			col_off = CB'(nx);
			row_off = (ny < 0) ? '0 : CB'(ny);
			if (done) begin
				circle_active = 1'b0;
				n_circles++;
			end
		endfunction

		// Compare one accepted pixel with the oldest expectation
		function void check_pixel(logic signed [PB-1:0] px, logic signed [PB-1:0] py,
				logic last, logic done);
			pixel_t e;
			if (expected_pixels.size() == 0) begin
				$error("unexpected pixel (%0d, %0d) last=%0b done=%0b", px, py, last, done);
				n_errors++;
				return;
			end
			e = expected_pixels.pop_front();
			n_pixels++;
			if (px !== e.px) begin
				$error("pixel_x mismatch: expected %0d, actual %0d", e.px, px);
				n_errors++;
			end
			if (py !== e.py) begin
				$error("pixel_y mismatch: expected %0d, actual %0d", e.py, py);
				n_errors++;
			end
			if (last !== e.last) begin
				$error("last_of_step mismatch: expected %0b, actual %0b", e.last, last);
				n_errors++;
			end
			if (done !== e.done) begin
				$error("circle_done mismatch: expected %0b, actual %0b", e.done, done);
				n_errors++;
			end
		endfunction
	endclass

	logic             clk;
	logic             arst_n = 1'b0;
	logic             s_axis_tvalid = 1'b0;
	logic             s_axis_tready;
	logic [S_W-1:0]   s_axis_tdata = '0;
	logic             s_axis_tuser = mcr_pkg::OP_START;
	logic             m_axis_tvalid;
	logic             m_axis_tready = 1'b0;
	logic [M_W-1:0]   m_axis_tdata;
	logic             m_axis_tlast;
	logic             m_axis_tuser;

	circle_scoreboard sb;
	int send_idle_pct = 0;
	int stall_pct = 0;
	int hold_left = 0;

	midpoint_circle_rasterizer u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	// Clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Pixel receiver: check accepted pixels, then pick next tready
	initial begin
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready)
				sb.check_pixel(m_axis_tdata[PB-1:0], m_axis_tdata[2*PB-1:PB],
					m_axis_tlast, m_axis_tuser);
			if (hold_left > 0) begin
				m_axis_tready <= 1'b0;
				hold_left--;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	// Offer one request, with a random idle gap first, and wait for acceptance
	task automatic send_req(logic op, logic [CB-1:0] cx, logic [CB-1:0] cy,
			logic [CB-1:0] r);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= S_W'({r, cy, cx});
		do @(posedge clk); while (!s_axis_tready);
		sb.take_request(op, cx, cy, r);
	endtask

	// Start a circle and step it until it ends or max_steps is reached
	task automatic run_circle(int cx, int cy, int r, int max_steps, inout int n);
		int steps;
		steps = 0;
		send_req(mcr_pkg::OP_START, CB'(cx), CB'(cy), CB'(r));
		n++;
		while (sb.circle_active && steps < max_steps) begin
			send_req(mcr_pkg::OP_STEP, CB'($urandom), CB'($urandom), CB'($urandom));
			steps++;
			n++;
		end
	endtask

	// Stop offering and wait until every owed pixel has come out
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (sb.expected_pixels.size() != 0);
		repeat (8) @(posedge clk);
	endtask

	function automatic int pick_coord();
		int sel;
		sel = $urandom_range(9);
		if (sel == 0)
			return 0;
		if (sel == 1)
			return C_MAX;
		return $urandom_range(C_MAX);
	endfunction

	// Mostly whole circles of small radius, some cut short, some idle steps
	task automatic random_circles(int count);
		int n, r, sel, cut;
		n = 0;
		while (n < count) begin
			sel = $urandom_range(99);
			if (sel < 75)
				r = $urandom_range(0, 16);
			else if (sel < 93)
				r = $urandom_range(17, 60);
			else
				r = $urandom_range(C_MAX);
			if ($urandom_range(9) == 0)
				cut = $urandom_range(1, 6);
			else if (r > 60)
				cut = $urandom_range(2, 10);
			else
				cut = 100;
			if (cut > count - n)
				cut = count - n;
			run_circle(pick_coord(), pick_coord(), r, cut, n);
			// stray step with nothing running
			if (!sb.circle_active && $urandom_range(3) == 0)
				send_req(mcr_pkg::OP_STEP, CB'($urandom), CB'($urandom), CB'($urandom));
		end
	endtask

	// Timeout
	initial begin
		#400_000;
		$display("Test completed with failures");
		$finish;
	end

	// Main sequence
	initial begin
		int n;
		n = 0;
		sb = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: idle step, zero radius, extremes, restart, x = y point
		send_req(mcr_pkg::OP_STEP, CB'(C_MAX), CB'(C_MAX), CB'(C_MAX));
		run_circle(0, 0, 0, 8, n);
		send_req(mcr_pkg::OP_STEP, '0, '0, '0);
		run_circle(C_MAX, C_MAX, C_MAX, 2, n);
		run_circle(0, C_MAX, C_MAX, 1, n);
		run_circle(C_MAX, 0, 1, 8, n);
		run_circle(2048, 2048, 3, 8, n);
		run_circle(1, C_MAX - 1, 6, 8, n);
		wait_drained();

		// random phases: none, sender idle, receiver stall, both
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = (ph == 1) ? 47 : (ph == 3) ? 21 : 0;
			stall_pct     = (ph == 2) ? 47 : (ph == 3) ? 21 : 0;
			if (ph == 2) begin
				// long receiver hold-off while requests keep coming
				hold_left = 160;
				run_circle(2048, 1024, 90, 40, n);
			end
			random_circles(36);
			wait_drained();
		end

		if (sb.expected_pixels.size() != 0) begin
			$error("%0d pixels never arrived", sb.expected_pixels.size());
			sb.n_errors++;
		end
		$display("Covered %0d requests, %0d circle starts, %0d finished circles",
			sb.n_requests, sb.n_starts, sb.n_circles);
		$display("Checked %0d pixels under idle, stall and hold-off phases", sb.n_pixels);
		if (sb.n_errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

@@ files.f @@
sv/mcr_pkg.sv
sv/mcr_core.sv
sv/mcr_emit.sv
sv/midpoint_circle_rasterizer.sv
sv/mcr_chk.sv
test/tb.sv
